// ===== design/ray_sphere_closest_hit_macros.svh =====
// assertion macros for the ray-sphere closest-hit checker
`ifndef RAY_SPHERE_CLOSEST_HIT_MACROS_SVH
`define RAY_SPHERE_CLOSEST_HIT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define RSCH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsch assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define RSCH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsch assertion failed");

`endif

// ===== design/rsch_pkg.sv =====
// shared types, constants and micro-op table of the ray-sphere closest-hit engine
package rsch_pkg;

  localparam int MAX_SPHERES_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int SLOT_W     = 4;
  localparam int CNT_W      = 5;
  localparam int IN_DATA_W  = 296;
  localparam int OUT_DATA_W = 40;

  // shared multiplier operand width, product and accumulator width
  localparam int MW    = 70;
  localparam int PW    = 2 * MW;
  // bits of the square root of the discriminant
  localparam int SQ_N  = 68;
  // width of the root denominator 2*a
  localparam int DEN_W = 65;

  localparam logic signed [31:0] DIST_INF = 32'sh7fff_ffff;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_TRACE = 1'b1;

  // register index as seen on paddr[2]
  localparam logic REG_SPHERE_COUNT = 1'b0;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0]        r;
  } sphere_t;

  typedef enum logic [3:0] {
    PR_DXDX, PR_DYDY, PR_DZDZ,
    PR_OXDX, PR_OYDY, PR_OZDZ,
    PR_OXOX, PR_OYOY, PR_OZOZ,
    PR_RR, PR_BB, PR_AC4
  } mul_pair_t;

  typedef enum logic [1:0] {
    DST_A, DST_B, DST_C, DST_DISC
  } mul_dst_t;

  typedef struct packed {
    mul_pair_t pair;
    logic      sub;
    logic      clr;
    logic      last;
    mul_dst_t  dst;
  } uop_t;

  // first micro-op of the per-sphere sequence
  localparam logic [3:0] UOP_SPHERE = 4'd3;

  typedef struct packed {
    logic  load_we;
    logic  ray_we;
    logic  mul_start;
    uop_t  uop;
    logic  rd;
    logic  ofs;
    logic  sqrt_start;
    logic  div_start;
    logic  div_sel;
    logic  test;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic eng_done;
    logic a_zero;
    logic disc_neg;
  } sts_t;

  // products in order: a = D.D, b = 2*O.D, c = O.O - r*r, disc = b*b - 4*a*c
  function automatic uop_t uop_of(logic [3:0] i);
    uop_t u;
    u = '{pair: PR_DXDX, sub: 1'b0, clr: 1'b0, last: 1'b0, dst: DST_A};
    case (i)
      4'd0:  u = '{pair: PR_DXDX, sub: 1'b0, clr: 1'b1, last: 1'b0, dst: DST_A};
      4'd1:  u = '{pair: PR_DYDY, sub: 1'b0, clr: 1'b0, last: 1'b0, dst: DST_A};
      4'd2:  u = '{pair: PR_DZDZ, sub: 1'b0, clr: 1'b0, last: 1'b1, dst: DST_A};
      4'd3:  u = '{pair: PR_OXDX, sub: 1'b0, clr: 1'b1, last: 1'b0, dst: DST_B};
      4'd4:  u = '{pair: PR_OYDY, sub: 1'b0, clr: 1'b0, last: 1'b0, dst: DST_B};
      4'd5:  u = '{pair: PR_OZDZ, sub: 1'b0, clr: 1'b0, last: 1'b1, dst: DST_B};
      4'd6:  u = '{pair: PR_OXOX, sub: 1'b0, clr: 1'b1, last: 1'b0, dst: DST_C};
      4'd7:  u = '{pair: PR_OYOY, sub: 1'b0, clr: 1'b0, last: 1'b0, dst: DST_C};
      4'd8:  u = '{pair: PR_OZOZ, sub: 1'b0, clr: 1'b0, last: 1'b0, dst: DST_C};
      4'd9:  u = '{pair: PR_RR,   sub: 1'b1, clr: 1'b0, last: 1'b1, dst: DST_C};
      4'd10: u = '{pair: PR_BB,   sub: 1'b0, clr: 1'b1, last: 1'b0, dst: DST_DISC};
      4'd11: u = '{pair: PR_AC4,  sub: 1'b1, clr: 1'b0, last: 1'b1, dst: DST_DISC};
      default: u = '{pair: PR_DXDX, sub: 1'b0, clr: 1'b1, last: 1'b1, dst: DST_A};
    endcase
    return u;
  endfunction

endpackage

// ===== design/rsch_ctrl.sv =====
// sequencer of the ray-sphere closest-hit engine
module rsch_ctrl #(
  parameter int MAX_SPHERES = rsch_pkg::MAX_SPHERES_DEF,
  localparam int CW = $clog2(MAX_SPHERES + 1),
  localparam int IW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_action,
  output logic                       in_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  input  logic [rsch_pkg::CNT_W-1:0] sphere_count,
  input  rsch_pkg::sts_t             sts,
  output rsch_pkg::cmd_t             cmd,
  output logic [IW-1:0]              idx
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_MUL   = 13'b0000000000010,
    S_MWAIT = 13'b0000000000100,
    S_LCHK  = 13'b0000000001000,
    S_RD    = 13'b0000000010000,
    S_DCHK  = 13'b0000000100000,
    S_SQRT  = 13'b0000001000000,
    S_SWAIT = 13'b0000010000000,
    S_DIV   = 13'b0000100000000,
    S_DWAIT = 13'b0001000000000,
    S_TEST  = 13'b0010000000000,
    S_NEXT  = 13'b0100000000000,
    S_FIN   = 13'b1000000000000
  } state_t;

  state_t         state_r, state_nxt;
  logic [3:0]     pidx_r, pidx_nxt;
  logic [CW-1:0]  idx_r, idx_nxt;
  logic           rsel_r, rsel_nxt;
  logic           ovalid_r, ovalid_nxt;
  logic [CW-1:0]  n_lim;
  logic           fire;
  rsch_pkg::uop_t uop;

  assign n_lim = (32'(sphere_count) > MAX_SPHERES) ? CW'(MAX_SPHERES) : CW'(sphere_count);
  assign in_ready = (state_r == S_IDLE);
  assign fire = in_valid && in_ready;
  assign uop = rsch_pkg::uop_of(pidx_r);
  assign out_valid = ovalid_r;
  assign idx = idx_r[IW-1:0];

  always_comb begin
    state_nxt  = state_r;
    pidx_nxt   = pidx_r;
    idx_nxt    = idx_r;
    rsel_nxt   = rsel_r;
    ovalid_nxt = ovalid_r;
    cmd = '0;
    cmd.uop = uop;
    cmd.div_sel = rsel_r;
    if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (fire) begin
          idx_nxt = '0;
          pidx_nxt = '0;
          if (in_action == rsch_pkg::ACT_TRACE) begin
            cmd.ray_we = 1'b1;
            state_nxt = S_MUL;
          end else begin
            cmd.load_we = 1'b1;
            state_nxt = S_FIN;
          end
        end
      end
      S_MUL: begin
        cmd.mul_start = 1'b1;
        state_nxt = S_MWAIT;
      end
      S_MWAIT: begin
        if (sts.eng_done) begin
          pidx_nxt = pidx_r + 4'd1;
          if (uop.last && uop.dst == rsch_pkg::DST_A) begin
            state_nxt = S_LCHK;
          end else if (uop.last && uop.dst == rsch_pkg::DST_DISC) begin
            state_nxt = S_DCHK;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_LCHK: begin
        pidx_nxt = rsch_pkg::UOP_SPHERE;
        if (sts.a_zero || idx_r >= n_lim) begin
          state_nxt = S_FIN;
        end else begin
          cmd.rd = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.ofs = 1'b1;
        state_nxt = S_MUL;
      end
      S_DCHK: begin
        rsel_nxt = 1'b0;
        state_nxt = sts.disc_neg ? S_NEXT : S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_start = 1'b1;
        state_nxt = S_SWAIT;
      end
      S_SWAIT: begin
        if (sts.eng_done) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.eng_done) begin
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        // far root first, then near root
        cmd.test = 1'b1;
        if (!rsel_r) begin
          rsel_nxt = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        idx_nxt = idx_r + CW'(1);
        state_nxt = S_LCHK;
      end
      S_FIN: begin
        if (!ovalid_r || out_ready) begin
          cmd.out_load = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pidx_r   <= '0;
      idx_r    <= '0;
      rsel_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pidx_r   <= pidx_nxt;
      idx_r    <= idx_nxt;
      rsel_r   <= rsel_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

// ===== design/rsch_dp.sv =====
// datapath: sphere table, bit-serial multiplier, square root, divider, best-hit tracking
module rsch_dp #(
  parameter int MAX_SPHERES = rsch_pkg::MAX_SPHERES_DEF,
  parameter int FRAC_BITS   = rsch_pkg::FRAC_BITS_DEF,
  localparam int IW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [rsch_pkg::IN_DATA_W-1:0]  in_tdata,
  input  rsch_pkg::cmd_t                  cmd,
  input  logic [IW-1:0]                   idx,
  output rsch_pkg::sts_t                  sts,
  output logic                            out_hit,
  output logic [rsch_pkg::OUT_DATA_W-1:0] out_data
);

  localparam int MW    = rsch_pkg::MW;
  localparam int PW    = rsch_pkg::PW;
  localparam int SQ_N  = rsch_pkg::SQ_N;
  localparam int DEN_W = rsch_pkg::DEN_W;
  localparam int DW    = MW + FRAC_BITS;
  localparam int CNTW  = $clog2(DW + 1);
  localparam logic [DW-1:0] Q_POS_MAX = DW'(32'h7fff_ffff);
  localparam logic [DW-1:0] Q_NEG_MAX = DW'(32'h8000_0000);

  typedef enum logic [3:0] {
    E_IDLE = 4'b0001,
    E_MUL  = 4'b0010,
    E_SQRT = 4'b0100,
    E_DIV  = 4'b1000
  } eng_t;

  // input fields
  logic [3:0]         f_slot;
  logic signed [31:0] f_px, f_py, f_pz, f_dx, f_dy, f_dz, f_near, f_far;
  logic [30:0]        f_rad;

  assign f_slot = in_tdata[3:0];
  assign f_px   = in_tdata[35:4];
  assign f_py   = in_tdata[67:36];
  assign f_pz   = in_tdata[99:68];
  assign f_rad  = in_tdata[130:100];
  assign f_dx   = in_tdata[162:131];
  assign f_dy   = in_tdata[194:163];
  assign f_dz   = in_tdata[226:195];
  assign f_near = in_tdata[258:227];
  assign f_far  = in_tdata[290:259];

  rsch_pkg::sphere_t table_mem [MAX_SPHERES];
  rsch_pkg::sphere_t rd_q;

  logic signed [31:0] px_r, py_r, pz_r, dx_r, dy_r, dz_r, near_r, far_r;
  logic signed [32:0] ox_r, oy_r, oz_r;
  logic [63:0]        a_r;
  logic signed [MW-1:0] b_r, c_r;
  logic signed [PW-1:0] disc_r, acc_r;
  logic [SQ_N-1:0]    s_r;
  logic signed [31:0] t_r, best_r;
  logic [3:0]         slot_r;
  logic               hit_r;
  logic               out_hit_r;
  logic [rsch_pkg::OUT_DATA_W-1:0] out_data_r;

  eng_t            eng_r, eng_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            done;

  // multiplier state
  logic [PW-1:0]   m_a_r, m_p_r;
  logic [MW-1:0]   m_b_r;
  logic            m_neg_r;
  rsch_pkg::uop_t  m_uop_r;
  // square root state
  logic [2*SQ_N-1:0] q_x_r;
  logic [SQ_N+1:0]   q_rem_r;
  logic [SQ_N-1:0]   q_root_r;
  // divider state
  logic [DW-1:0]     d_q_r;
  logic [DEN_W-1:0]  d_rem_r;
  logic              d_neg_r;

  logic signed [MW-1:0] opx, opy, dnum;
  logic [MW-1:0]        magx, magy, dmag;
  logic signed [PW-1:0] prod_s, term, accum;
  logic [SQ_N+3:0]      s_rem2, s_trial, s_diff;
  logic                 s_ge;
  logic [DEN_W:0]       d_rs, d_diff;
  logic                 d_ge;
  logic [DEN_W-1:0]     den;
  logic signed [31:0]   t_sat;
  logic                 wr_ok;

  assign done = (eng_r != E_IDLE) && (cnt_r == '0);
  assign sts.eng_done = done;
  assign sts.a_zero = (a_r == '0);
  assign sts.disc_neg = disc_r[PW-1];
  assign out_hit = out_hit_r;
  assign out_data = out_data_r;
  assign den = {a_r, 1'b0};
  assign wr_ok = (32'(f_slot) < MAX_SPHERES);

  always_comb begin
    opx = MW'(dx_r);
    opy = MW'(dx_r);
    case (cmd.uop.pair)
      rsch_pkg::PR_DXDX: begin opx = MW'(dx_r); opy = MW'(dx_r); end
      rsch_pkg::PR_DYDY: begin opx = MW'(dy_r); opy = MW'(dy_r); end
      rsch_pkg::PR_DZDZ: begin opx = MW'(dz_r); opy = MW'(dz_r); end
      rsch_pkg::PR_OXDX: begin opx = MW'(ox_r); opy = MW'(dx_r); end
      rsch_pkg::PR_OYDY: begin opx = MW'(oy_r); opy = MW'(dy_r); end
      rsch_pkg::PR_OZDZ: begin opx = MW'(oz_r); opy = MW'(dz_r); end
      rsch_pkg::PR_OXOX: begin opx = MW'(ox_r); opy = MW'(ox_r); end
      rsch_pkg::PR_OYOY: begin opx = MW'(oy_r); opy = MW'(oy_r); end
      rsch_pkg::PR_OZOZ: begin opx = MW'(oz_r); opy = MW'(oz_r); end
      rsch_pkg::PR_RR: begin
        opx = {{(MW-31){1'b0}}, rd_q.r};
        opy = {{(MW-31){1'b0}}, rd_q.r};
      end
      rsch_pkg::PR_BB: begin opx = b_r; opy = b_r; end
      rsch_pkg::PR_AC4: begin opx = {{(MW-66){1'b0}}, a_r, 2'b00}; opy = c_r; end
      default: begin opx = MW'(dx_r); opy = MW'(dx_r); end
    endcase
    magx = opx[MW-1] ? MW'(-opx) : MW'(opx);
    magy = opy[MW-1] ? MW'(-opy) : MW'(opy);
  end

  always_comb begin
    prod_s = m_neg_r ? -$signed(m_p_r) : $signed(m_p_r);
    term   = m_uop_r.sub ? -prod_s : prod_s;
    accum  = (m_uop_r.clr ? '0 : acc_r) + term;
  end

  // one root bit per cycle
  always_comb begin
    s_rem2  = {q_rem_r, q_x_r[2*SQ_N-1 -: 2]};
    s_trial = {2'b00, q_root_r, 2'b01};
    s_ge    = (s_rem2 >= s_trial);
    s_diff  = s_rem2 - s_trial;
  end

  // one quotient bit per cycle, magnitudes only
  always_comb begin
    dnum = cmd.div_sel ? (-b_r - MW'({1'b0, s_r})) : (MW'({1'b0, s_r}) - b_r);
    dmag = dnum[MW-1] ? MW'(-dnum) : MW'(dnum);
    d_rs   = {d_rem_r, d_q_r[DW-1]};
    d_ge   = (d_rs >= {1'b0, den});
    d_diff = d_rs - {1'b0, den};
  end

  always_comb begin
    if (!d_neg_r) begin
      t_sat = (d_q_r > Q_POS_MAX) ? rsch_pkg::DIST_INF : $signed(d_q_r[31:0]);
    end else begin
      t_sat = (d_q_r > Q_NEG_MAX) ? -rsch_pkg::DIST_INF - 32'sd1 : -$signed(d_q_r[31:0]);
    end
  end

  always_comb begin
    eng_nxt = eng_r;
    cnt_nxt = cnt_r;
    case (eng_r)
      E_IDLE: begin
        if (cmd.mul_start) begin
          eng_nxt = E_MUL;
          cnt_nxt = CNTW'(MW);
        end else if (cmd.sqrt_start) begin
          eng_nxt = E_SQRT;
          cnt_nxt = CNTW'(SQ_N);
        end else if (cmd.div_start) begin
          eng_nxt = E_DIV;
          cnt_nxt = CNTW'(DW);
        end
      end
      E_MUL, E_SQRT, E_DIV: begin
        if (done) begin
          eng_nxt = E_IDLE;
        end else begin
          cnt_nxt = cnt_r - CNTW'(1);
        end
      end
      default: eng_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eng_r <= E_IDLE;
      cnt_r <= '0;
    end else begin
      eng_r <= eng_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_we && wr_ok) begin
      table_mem[IW'(f_slot)] <= '{cx: f_px, cy: f_py, cz: f_pz, r: f_rad};
    end
    if (cmd.rd) begin
      rd_q <= table_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ray_we) begin
      px_r <= f_px;  py_r <= f_py;  pz_r <= f_pz;
      dx_r <= f_dx;  dy_r <= f_dy;  dz_r <= f_dz;
      near_r <= f_near;
      far_r  <= f_far;
    end
    if (cmd.ofs) begin
      ox_r <= {px_r[31], px_r} - {rd_q.cx[31], rd_q.cx};
      oy_r <= {py_r[31], py_r} - {rd_q.cy[31], rd_q.cy};
      oz_r <= {pz_r[31], pz_r} - {rd_q.cz[31], rd_q.cz};
    end

    if (cmd.mul_start) begin
      m_a_r   <= {{MW{1'b0}}, magx};
      m_b_r   <= magy;
      m_p_r   <= '0;
      m_neg_r <= opx[MW-1] ^ opy[MW-1];
      m_uop_r <= cmd.uop;
    end else if (eng_r == E_MUL && !done) begin
      if (m_b_r[0]) begin
        m_p_r <= m_p_r + m_a_r;
      end
      m_a_r <= {m_a_r[PW-2:0], 1'b0};
      m_b_r <= {1'b0, m_b_r[MW-1:1]};
    end else if (eng_r == E_MUL && done) begin
      acc_r <= accum;
      if (m_uop_r.last) begin
        case (m_uop_r.dst)
          rsch_pkg::DST_A:    a_r <= accum[63:0];
          rsch_pkg::DST_B:    b_r <= {accum[MW-2:0], 1'b0};
          rsch_pkg::DST_C:    c_r <= accum[MW-1:0];
          rsch_pkg::DST_DISC: disc_r <= accum;
          default:            disc_r <= accum;
        endcase
      end
    end

    if (cmd.sqrt_start) begin
      q_x_r    <= disc_r[2*SQ_N-1:0];
      q_rem_r  <= '0;
      q_root_r <= '0;
    end else if (eng_r == E_SQRT && !done) begin
      q_x_r    <= {q_x_r[2*SQ_N-3:0], 2'b00};
      q_rem_r  <= s_ge ? s_diff[SQ_N+1:0] : s_rem2[SQ_N+1:0];
      q_root_r <= {q_root_r[SQ_N-2:0], s_ge};
    end else if (eng_r == E_SQRT && done) begin
      s_r <= q_root_r;
    end

    if (cmd.div_start) begin
      d_q_r   <= {dmag, {FRAC_BITS{1'b0}}};
      d_rem_r <= '0;
      d_neg_r <= dnum[MW-1];
    end else if (eng_r == E_DIV && !done) begin
      d_rem_r <= d_ge ? d_diff[DEN_W-1:0] : d_rs[DEN_W-1:0];
      d_q_r   <= {d_q_r[DW-2:0], d_ge};
    end else if (eng_r == E_DIV && done) begin
      t_r <= t_sat;
    end

    if (cmd.out_load) begin
      out_hit_r  <= hit_r;
      out_data_r <= {4'b0000, best_r, slot_r};
    end
  end

  // best-so-far is control state of the trace
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= rsch_pkg::DIST_INF;
      slot_r <= '0;
      hit_r  <= 1'b0;
    end else if (cmd.load_we || cmd.ray_we) begin
      best_r <= rsch_pkg::DIST_INF;
      slot_r <= '0;
      hit_r  <= 1'b0;
    end else if (cmd.test && t_r < best_r && t_r > near_r && t_r < far_r) begin
      best_r <= t_r;
      slot_r <= 4'(idx);
      hit_r  <= 1'b1;
    end
  end

endmodule

// ===== design/ray_sphere_closest_hit.sv =====
// top level of the ray-sphere closest-hit engine
// A load request writes one sphere into the table and answers with hit 0. A trace
// request runs the spheres 0 .. n-1, n being the sphere count saturated at MAX_SPHERES,
// through one shared bit-serial multiplier (MW = 70), a one-bit-per-cycle square root
// and a one-bit-per-cycle divider, and ends early when the ray direction is zero;
// distances are Q16.16 at the default FRAC_BITS. The multiplier dominates. One request
// is in work at a time; the next is taken while the previous result still waits on the
// output.
module ray_sphere_closest_hit #(
  parameter int MAX_SPHERES = rsch_pkg::MAX_SPHERES_DEF,
  parameter int FRAC_BITS   = rsch_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // slot[3:0], pos_x[35:4], pos_y[67:36], pos_z[99:68], sphere_radius[130:100],
  // dir_x[162:131], dir_y[194:163], dir_z[226:195], near_limit[258:227],
  // far_limit[290:259], zero fill above
  input  logic [295:0] in_tdata,
  // action[0]
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // hit_slot[3:0], hit_distance[35:4], zero fill above
  output logic [39:0]  out_tdata,
  // hit[0]
  output logic [0:0]   out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int IW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;

  logic [rsch_pkg::CNT_W-1:0] count_r, count_nxt;
  rsch_pkg::cmd_t cmd;
  rsch_pkg::sts_t sts;
  logic [IW-1:0]  idx;
  logic           hit;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == rsch_pkg::REG_SPHERE_COUNT) ? 32'(count_r) : 32'd0;

  always_comb begin
    count_nxt = count_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
        cfg_paddr[2] == rsch_pkg::REG_SPHERE_COUNT) begin
      count_nxt = cfg_pwdata[rsch_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  rsch_ctrl #(
    .MAX_SPHERES(MAX_SPHERES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_action    (in_tuser[0]),
    .in_ready     (in_tready),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .sphere_count (count_r),
    .sts          (sts),
    .cmd          (cmd),
    .idx          (idx)
  );

  rsch_dp #(
    .MAX_SPHERES(MAX_SPHERES),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tdata (in_tdata),
    .cmd      (cmd),
    .idx      (idx),
    .sts      (sts),
    .out_hit  (hit),
    .out_data (out_tdata)
  );

  assign out_tuser = hit;

endmodule

// ===== design/rsch_checker.sv =====
// port-level checker of the ray-sphere closest-hit engine, bound to the top level
`include "ray_sphere_closest_hit_macros.svh"

module rsch_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [295:0] in_tdata,
  input logic [0:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [39:0]  out_tdata,
  input logic [0:0]   out_tuser,
  input logic         cfg_psel,
  input logic         cfg_penable,
  input logic         cfg_pwrite,
  input logic [2:0]   cfg_paddr,
  input logic [31:0]  cfg_pwdata,
  input logic [31:0]  cfg_prdata,
  input logic         cfg_pready
);

  // a stalled result holds
  `RSCH_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // a miss reports slot 0 at infinite distance
  `RSCH_ASSERT_IMP(a_miss_fmt, out_tvalid && !out_tuser[0], out_tdata[35:4] == 32'h7fff_ffff && out_tdata[3:0] == 4'd0)

  // a hit never lies at infinity
  `RSCH_ASSERT_IMP(a_hit_finite, out_tvalid && out_tuser[0], out_tdata[35:4] != 32'h7fff_ffff)

  // the count register reads back what was written
  `RSCH_ASSERT_NXT(a_cfg_rdbk, cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2], cfg_paddr[2] || cfg_prdata[4:0] == $past(cfg_pwdata[4:0]))

endmodule

bind ray_sphere_closest_hit rsch_checker u_rsch_checker (.*);
